// ===== src/least_squares_line_fit_defines.svh =====
// ---------------------------------------------------------------------------
// Least squares line fit: assertion macros
// Shared property shapes, clocked on clk_i and disabled while rst_ni is low.
// ---------------------------------------------------------------------------
`ifndef LEAST_SQUARES_LINE_FIT_DEFINES_SVH
`define LEAST_SQUARES_LINE_FIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LSF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define LSF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/lsf_pkg.sv =====
// ---------------------------------------------------------------------------
// Least squares line fit package
// Payload types, controller/datapath interface structs and defaults.
// ---------------------------------------------------------------------------
package lsf_pkg;

  localparam int unsigned X_W   = 12;
  localparam int unsigned Y_W   = 12;
  localparam int unsigned RES_W = 32;

  localparam int unsigned COORD_BITS_DEF = 12;
  localparam int unsigned MAX_POINTS_DEF = 65536;
  localparam int unsigned FRAC_BITS_DEF  = 16;

  typedef struct packed {
    logic [X_W-1:0] x;
    logic [Y_W-1:0] y;
    logic           last;
  } lsf_in_t;

  typedef struct packed {
    logic signed [RES_W-1:0] slope;
    logic signed [RES_W-1:0] intercept;
    logic                    degenerate;
    logic                    saturated;
  } lsf_out_t;

  // Product selected for the shared multiplier
  typedef enum logic [2:0] {
    OP_N_SXX  = 3'd0,
    OP_SX_SX  = 3'd1,
    OP_N_SXY  = 3'd2,
    OP_SX_SY  = 3'd3,
    OP_SXX_SY = 3'd4,
    OP_SXY_SX = 3'd5
  } lsf_op_e;

  typedef struct packed {
    logic    in_ready;
    logic    mul_start;
    lsf_op_e op;
    logic    t1_load;
    logic    den_load;
    logic    num_load;
    logic    div_start;
    logic    slope_load;
    logic    icpt_load;
    logic    out_load;
  } lsf_cmd_t;

  typedef struct packed {
    logic p_last;
    logic mul_done;
    logic div_done;
    logic den_zero;
    logic out_free;
  } lsf_sts_t;

endpackage

// ===== src/lsf_mul.sv =====
// ---------------------------------------------------------------------------
// Least squares line fit: serial multiplier
// Unsigned shift-and-add multiplier, one multiplier bit per cycle.
// ---------------------------------------------------------------------------
module lsf_mul import lsf_pkg::*; #(
  parameter int unsigned A_W = 40,
  parameter int unsigned B_W = 29,
  parameter int unsigned P_W = 69
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [A_W-1:0] a_i,
  input  logic [B_W-1:0] b_i,
  output logic           done_o,
  output logic [P_W-1:0] prod_o
);

  localparam int unsigned C_W = $clog2(B_W + 1);

  logic           busy_q, done_q;
  logic [C_W-1:0] cnt_q;
  logic [P_W-1:0] a_q, acc_q;
  logic [B_W-1:0] b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + C_W'(1);
      if (cnt_q == C_W'(B_W - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= P_W'(a_i);
      b_q   <= b_i;
      acc_q <= '0;
    end else if (busy_q) begin
      if (b_q[0]) begin
        acc_q <= acc_q + a_q;
      end
      a_q <= a_q << 1;
      b_q <= b_q >> 1;
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

// ===== src/lsf_div.sv =====
// ---------------------------------------------------------------------------
// Least squares line fit: serial divider
// Restoring unsigned divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module lsf_div import lsf_pkg::*; #(
  parameter int unsigned D_W = 69,
  parameter int unsigned N_W = 85
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [N_W-1:0] dividend_i,
  input  logic [D_W-1:0] divisor_i,
  output logic           done_o,
  output logic [N_W-1:0] quot_o
);

  localparam int unsigned C_W = $clog2(N_W + 1);

  logic           busy_q, done_q;
  logic [C_W-1:0] cnt_q;
  logic [N_W-1:0] dq_q;
  logic [D_W-1:0] rem_q, dsr_q;
  logic [D_W:0]   rem_sh, diff;
  logic           ge;

  // Shift in the next dividend bit, subtract when the divisor fits
  assign rem_sh = {rem_q, dq_q[N_W-1]};
  assign ge     = rem_sh >= {1'b0, dsr_q};
  assign diff   = rem_sh - {1'b0, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + C_W'(1);
      if (cnt_q == C_W'(N_W - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dq_q  <= dividend_i;
      dsr_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? diff[D_W-1:0] : rem_sh[D_W-1:0];
      dq_q  <= {dq_q[N_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = dq_q;

endmodule

// ===== src/lsf_datapath.sv =====
// ---------------------------------------------------------------------------
// Least squares line fit: datapath
// Point products and sums, fit terms, divider results and output register.
// ---------------------------------------------------------------------------
module lsf_datapath import lsf_pkg::*; #(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF,
  parameter int unsigned MAX_POINTS = MAX_POINTS_DEF,
  parameter int unsigned FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  lsf_cmd_t cmd_i,
  output lsf_sts_t sts_o,
  input  logic     in_valid_i,
  input  lsf_in_t  in_req_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output lsf_out_t out_res_o
);

  `include "least_squares_line_fit_defines.svh"

  localparam int unsigned CW     = (COORD_BITS < X_W) ? COORD_BITS : X_W;
  localparam int unsigned CNT_W  = $clog2(MAX_POINTS + 1);
  localparam int unsigned SX_W   = CW + CNT_W;
  localparam int unsigned SXX_W  = 2 * CW + CNT_W;
  localparam int unsigned PROD_W = SXX_W + SX_W;
  localparam int unsigned DVD_W  = PROD_W + FRAC_BITS;
  localparam int unsigned QX_W   = (DVD_W > RES_W + 1) ? DVD_W : RES_W + 1;

  // Product stage
  logic              pv_q, plast_q;
  logic [CW-1:0]     px_q, py_q;
  logic [2*CW-1:0]   pxy_q, pxx_q;
  logic [CW-1:0]     xm, ym;

  // Sums
  logic [CNT_W-1:0]  cnt_q;
  logic [SX_W-1:0]   sx_q, sy_q;
  logic [SXX_W-1:0]  sxy_q, sxx_q;

  // Fit terms
  logic [SXX_W-1:0]  mul_a;
  logic [SX_W-1:0]   mul_b;
  logic [PROD_W-1:0] prod, t1_q, den_q, mag_q;
  logic              neg_q, mul_done;
  logic [DVD_W-1:0]  quot;
  logic              div_done;

  logic [QX_W-1:0]   qx;
  logic [RES_W-1:0]  qlow, qval;
  logic              qsat;

  logic [RES_W-1:0]  slope_q, icpt_q;
  logic              sat_s_q, sat_i_q;

  logic              out_valid_q;
  lsf_out_t          out_q;
  logic              in_fire;

  assign in_fire = in_valid_i && cmd_i.in_ready;
  assign xm      = in_req_i.x[CW-1:0];
  assign ym      = in_req_i.y[CW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= 1'b0;
    end else begin
      pv_q <= in_fire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      plast_q <= in_req_i.last;
      px_q    <= xm;
      py_q    <= ym;
      pxy_q   <= (2*CW)'(xm) * (2*CW)'(ym);
      pxx_q   <= (2*CW)'(xm) * (2*CW)'(xm);
    end
  end

  // Accumulate; points past the capacity are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      sx_q  <= '0;
      sy_q  <= '0;
      sxy_q <= '0;
      sxx_q <= '0;
    end else if (cmd_i.out_load) begin
      cnt_q <= '0;
      sx_q  <= '0;
      sy_q  <= '0;
      sxy_q <= '0;
      sxx_q <= '0;
    end else if (pv_q && (cnt_q < CNT_W'(MAX_POINTS))) begin
      cnt_q <= cnt_q + CNT_W'(1);
      sx_q  <= sx_q + SX_W'(px_q);
      sy_q  <= sy_q + SX_W'(py_q);
      sxy_q <= sxy_q + SXX_W'(pxy_q);
      sxx_q <= sxx_q + SXX_W'(pxx_q);
    end
  end

  // Operand select: the narrower factor goes to the serial side
  always_comb begin
    unique case (cmd_i.op)
      OP_N_SXX: begin
        mul_a = sxx_q;
        mul_b = SX_W'(cnt_q);
      end
      OP_SX_SX: begin
        mul_a = SXX_W'(sx_q);
        mul_b = sx_q;
      end
      OP_N_SXY: begin
        mul_a = sxy_q;
        mul_b = SX_W'(cnt_q);
      end
      OP_SX_SY: begin
        mul_a = SXX_W'(sx_q);
        mul_b = sy_q;
      end
      OP_SXX_SY: begin
        mul_a = sxx_q;
        mul_b = sy_q;
      end
      OP_SXY_SX: begin
        mul_a = sxy_q;
        mul_b = sx_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  lsf_mul #(
    .A_W (SXX_W),
    .B_W (SX_W),
    .P_W (PROD_W)
  ) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (prod)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.t1_load) begin
      t1_q <= prod;
    end
    if (cmd_i.den_load) begin
      den_q <= t1_q - prod;
    end
    if (cmd_i.num_load) begin
      neg_q <= t1_q < prod;
      mag_q <= (t1_q < prod) ? (prod - t1_q) : (t1_q - prod);
    end
  end

  lsf_div #(
    .D_W (PROD_W),
    .N_W (DVD_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (DVD_W'(mag_q) << FRAC_BITS),
    .divisor_i  (den_q),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  // Apply the sign and clamp to the 32-bit range
  assign qx   = QX_W'(quot);
  assign qlow = qx[RES_W-1:0];
  assign qsat = (|qx[QX_W-1:RES_W])
             || (neg_q ? (qlow > {1'b1, {(RES_W - 1){1'b0}}}) : qlow[RES_W-1]);
  always_comb begin
    if (neg_q) begin
      qval = qsat ? {1'b1, {(RES_W - 1){1'b0}}} : (RES_W'(0) - qlow);
    end else begin
      qval = qsat ? {1'b0, {(RES_W - 1){1'b1}}} : qlow;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.slope_load) begin
      slope_q <= qval;
      sat_s_q <= qsat;
    end
    if (cmd_i.icpt_load) begin
      icpt_q  <= qval;
      sat_i_q <= qsat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      if (den_q == '0) begin
        out_q.slope      <= '0;
        out_q.intercept  <= '0;
        out_q.degenerate <= 1'b1;
        out_q.saturated  <= 1'b0;
      end else begin
        out_q.slope      <= $signed(slope_q);
        out_q.intercept  <= $signed(icpt_q);
        out_q.degenerate <= 1'b0;
        out_q.saturated  <= sat_s_q || sat_i_q;
      end
    end
  end

  assign sts_o.p_last   = pv_q && plast_q;
  assign sts_o.mul_done = mul_done;
  assign sts_o.div_done = div_done;
  assign sts_o.den_zero = den_q == '0;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;

  `LSF_ASSERT_NXT(a_sums_cleared, cmd_i.out_load,
                  (cnt_q == '0) && (sxx_q == '0) && out_valid_q,
                  "sums not cleared or result not posted after a fit")

endmodule

// ===== src/lsf_ctrl.sv =====
// ---------------------------------------------------------------------------
// Least squares line fit: controller
// Sequences the six products, two divisions and the result write.
// ---------------------------------------------------------------------------
module lsf_ctrl import lsf_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  lsf_sts_t sts_i,
  output lsf_cmd_t cmd_o
);

  `include "least_squares_line_fit_defines.svh"

  typedef enum logic [6:0] {
    S_ACC    = 7'b0000001,
    S_MSTART = 7'b0000010,
    S_MWAIT  = 7'b0000100,
    S_DENCHK = 7'b0001000,
    S_DSTART = 7'b0010000,
    S_DWAIT  = 7'b0100000,
    S_OUT    = 7'b1000000
  } lsf_state_e;

  lsf_state_e state_q, state_d;
  lsf_op_e    op_q, op_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_ACC;
      op_q    <= OP_N_SXX;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
    end
  end

  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    cmd_o   = '0;
    cmd_o.op = op_q;
    unique case (state_q)
      S_ACC: begin
        cmd_o.in_ready = !sts_i.p_last;
        if (sts_i.p_last) begin
          op_d    = OP_N_SXX;
          state_d = S_MSTART;
        end
      end
      S_MSTART: begin
        cmd_o.mul_start = 1'b1;
        state_d         = S_MWAIT;
      end
      S_MWAIT: begin
        if (sts_i.mul_done) begin
          unique case (op_q) inside
            OP_N_SXX: begin
              cmd_o.t1_load = 1'b1;
              op_d          = OP_SX_SX;
              state_d       = S_MSTART;
            end
            OP_SX_SX: begin
              cmd_o.den_load = 1'b1;
              state_d        = S_DENCHK;
            end
            OP_N_SXY: begin
              cmd_o.t1_load = 1'b1;
              op_d          = OP_SX_SY;
              state_d       = S_MSTART;
            end
            OP_SXX_SY: begin
              cmd_o.t1_load = 1'b1;
              op_d          = OP_SXY_SX;
              state_d       = S_MSTART;
            end
            OP_SX_SY, OP_SXY_SX: begin
              cmd_o.num_load = 1'b1;
              state_d        = S_DSTART;
            end
            default: begin
              state_d = S_ACC;
            end
          endcase
        end
      end
      S_DENCHK: begin
        // Fewer than two distinct x: skip the divisions
        if (sts_i.den_zero) begin
          state_d = S_OUT;
        end else begin
          op_d    = OP_N_SXY;
          state_d = S_MSTART;
        end
      end
      S_DSTART: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_DWAIT;
      end
      S_DWAIT: begin
        if (sts_i.div_done) begin
          if (op_q == OP_SX_SY) begin
            cmd_o.slope_load = 1'b1;
            op_d             = OP_SXX_SY;
            state_d          = S_MSTART;
          end else begin
            cmd_o.icpt_load = 1'b1;
            state_d         = S_OUT;
          end
        end
      end
      S_OUT: begin
        // Hold until the output register can take the result
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_ACC;
        end
      end
      default: begin
        state_d = S_ACC;
      end
    endcase
  end

  `LSF_ASSERT_IMP(a_mul_done_wait, sts_i.mul_done, state_q == S_MWAIT,
                  "multiplier finished outside its wait state")
  `LSF_ASSERT_IMP(a_div_done_wait, sts_i.div_done, state_q == S_DWAIT,
                  "divider finished outside its wait state")
  `LSF_ASSERT_IMP(a_out_no_overrun, cmd_o.out_load, sts_i.out_free,
                  "result written over one still waiting")

endmodule

// ===== src/least_squares_line_fit.sv =====
// ---------------------------------------------------------------------------
// Least squares line fit
// Accumulates points and fits a line by ordinary least squares per set.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel in_valid_i/in_ready_o carries one point request (x, y,
//   last). Points are taken one per cycle while no fit is running. The
//   request with last set closes the set: it is accumulated, then in_ready_o
//   drops while the fit runs.
//   The fit uses a serial shift-add multiplier for six products and a
//   restoring divider for two quotients, one bit per cycle each. The
//   multiplier's serial operand is SX_W = COORD_BITS + clog2(MAX_POINTS+1)
//   bits wide and the dividend is DVD_W = 3*COORD_BITS +
//   2*clog2(MAX_POINTS+1) + FRAC_BITS bits wide. A degenerate set (zero
//   denominator) skips the remaining products and both divisions.
//   Output channel out_valid_o/out_ready_i carries one result per set from
//   an output register; new points are taken while it waits. A stalled
//   receiver holds the result and delays the next fit's write and new points.
//   Reset clears all sums and drops any pending result.
// ---------------------------------------------------------------------------
module least_squares_line_fit import lsf_pkg::*; #(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF,
  parameter int unsigned MAX_POINTS = MAX_POINTS_DEF,
  parameter int unsigned FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  lsf_in_t  in_req_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output lsf_out_t out_res_o
);

  lsf_cmd_t cmd;
  lsf_sts_t sts;

  lsf_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  lsf_datapath #(
    .COORD_BITS (COORD_BITS),
    .MAX_POINTS (MAX_POINTS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_valid_i  (in_valid_i),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_res_o   (out_res_o)
  );

  assign in_ready_o = cmd.in_ready;

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Least squares line fit testbench
// Streams point sets into the block and checks every fitted slope, intercept
// and flag against an exact wide-integer line fit kept in a scoreboard.
// Covers directed corner sets and random sets, with random gaps on both
// channels.
// ---------------------------------------------------------------------------
module tb_top;
  import lsf_pkg::*;

  localparam int unsigned COORD_MAX  = (1 << COORD_BITS_DEF) - 1;
  localparam int unsigned RAND_ITEMS = 1680;
  localparam int unsigned TAIL_WAIT  = 400;

  class fit_scoreboard;
    bit [16:0]   n_pts;
    bit [27:0]   sum_x;
    bit [27:0]   sum_y;
    bit [39:0]   sum_xy;
    bit [39:0]   sum_xx;
    lsf_out_t    fits_due[$];
    int unsigned fails;

    function new();
      clear_sums();
      fails = 0;
    endfunction

    function void clear_sums();
      n_pts  = '0;
      sum_x  = '0;
      sum_y  = '0;
      sum_xy = '0;
      sum_xx = '0;
    endfunction

    function int unsigned pending();
      return fits_due.size();
    endfunction

    // Signed fixed-point (p - m) / den, truncated toward zero, clamped.
    function bit [31:0] fixed_ratio(bit [127:0] p, bit [127:0] m, bit [127:0] den,
                                    inout bit sat);
      bit         neg;
      bit [127:0] mag;
      bit [127:0] q;
      neg = p < m;
      mag = neg ? m - p : p - m;
      q   = (mag << FRAC_BITS_DEF) / den;
      if (!neg) begin
        if (q > 128'h7FFF_FFFF) begin
          sat = 1'b1;
          return 32'h7FFF_FFFF;
        end
        return q[31:0];
      end
      if (q > 128'h8000_0000) begin
        sat = 1'b1;
        return 32'h8000_0000;
      end
      return 32'h0 - q[31:0];
    endfunction

    function void note_point(lsf_in_t p);
      bit [39:0]  xv;
      bit [39:0]  yv;
      bit [127:0] den;
      bit         sat;
      lsf_out_t   fit;
      xv = 40'(p.x & COORD_MAX);
      yv = 40'(p.y & COORD_MAX);
      // Points past the set capacity are dropped, but their last flag still counts.
      if (n_pts < MAX_POINTS_DEF) begin
        n_pts++;
        sum_x  += 28'(xv);
        sum_y  += 28'(yv);
        sum_xy += xv * yv;
        sum_xx += xv * xv;
      end
      if (!p.last) return;
      den = 128'(n_pts) * 128'(sum_xx) - 128'(sum_x) * 128'(sum_x);
      fit = '0;
      sat = 1'b0;
      if (den == '0) begin
        fit.degenerate = 1'b1;
      end else begin
        fit.slope     = fixed_ratio(128'(n_pts) * 128'(sum_xy),
                                    128'(sum_x) * 128'(sum_y), den, sat);
        fit.intercept = fixed_ratio(128'(sum_xx) * 128'(sum_y),
                                    128'(sum_xy) * 128'(sum_x), den, sat);
        fit.saturated = sat;
      end
      fits_due = {fits_due, fit};
      clear_sums();
    endfunction

    function void check_fit(lsf_out_t got);
      lsf_out_t want;
      if (fits_due.size() == 0) begin
        $display("%0t: unexpected fit result slope=%0d intercept=%0d", $time,
                 got.slope, got.intercept);
        fails++;
        return;
      end
      want = fits_due.pop_front();
      if (got.slope !== want.slope) begin
        $display("%0t: slope expected %0d actual %0d", $time, want.slope, got.slope);
        fails++;
      end
      if (got.intercept !== want.intercept) begin
        $display("%0t: intercept expected %0d actual %0d", $time, want.intercept,
                 got.intercept);
        fails++;
      end
      if (got.degenerate !== want.degenerate) begin
        $display("%0t: degenerate expected %0b actual %0b", $time, want.degenerate,
                 got.degenerate);
        fails++;
      end
      if (got.saturated !== want.saturated) begin
        $display("%0t: saturated expected %0b actual %0b", $time, want.saturated,
                 got.saturated);
        fails++;
      end
    endfunction
  endclass

  logic     clk_i;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  logic     in_ready_o;
  lsf_in_t  in_req_i    = '0;
  logic     out_valid_o;
  logic     out_ready_i = 1'b0;
  lsf_out_t out_res_o;

  fit_scoreboard sb = new();
  bit            calm = 1'b0;
  int unsigned   sent_cnt = 0;

  least_squares_line_fit u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_res_o  (out_res_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #50_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // Result side: stall at random unless in a calm stretch.
  initial begin
    forever begin
      @(posedge clk_i);
      out_ready_i <= calm || ($urandom_range(99) >= 18);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) sb.note_point(in_req_i);
      if (out_valid_o && out_ready_i) sb.check_fit(out_res_o);
    end
  end

  function automatic lsf_in_t mk_point(int xv, int yv, bit is_last);
    lsf_in_t p;
    p.x    = (xv < 0) ? '0 : (xv > int'(COORD_MAX)) ? X_W'(COORD_MAX) : X_W'(xv);
    p.y    = (yv < 0) ? '0 : (yv > int'(COORD_MAX)) ? Y_W'(COORD_MAX) : Y_W'(yv);
    p.last = is_last;
    return p;
  endfunction

  task automatic send_point(input lsf_in_t p);
    if (!calm) begin
      while ($urandom_range(99) < 18) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b1;
    in_req_i   <= p;
    // Ready is settled mid-cycle; the request goes at the following edge.
    forever begin
      @(negedge clk_i);
      if (in_ready_o) break;
    end
    @(posedge clk_i);
    sent_cnt++;
  endtask

  // Hold off new requests until every fit has been returned.
  task automatic drain_fits();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  task automatic send_random_set(input int unsigned len);
    int unsigned shape;
    int          x0;
    int          y0;
    int          slope_k;
    int          xv;
    int          yv;
    shape   = $urandom_range(9);
    x0      = int'($urandom_range(COORD_MAX));
    y0      = int'($urandom_range(COORD_MAX));
    slope_k = int'($urandom_range(40)) - 20;
    for (int unsigned i = 0; i < len; i++) begin
      case (shape) inside
        4, 5: begin
          // Near-linear cloud around (x0, y0) with a little noise.
          xv = x0 - 64 + int'($urandom_range(127));
          yv = y0 + slope_k * (xv - x0) + int'($urandom_range(6)) - 3;
        end
        6: begin
          xv = x0;
          yv = int'($urandom_range(COORD_MAX));
        end
        7: begin
          xv = int'($urandom_range(15));
          yv = int'($urandom_range(15));
        end
        8: begin
          xv = ($urandom_range(2) == 0) ? int'($urandom_range(COORD_MAX)) :
               ($urandom_range(1) ? int'(COORD_MAX) : 0);
          yv = ($urandom_range(2) == 0) ? int'($urandom_range(COORD_MAX)) :
               ($urandom_range(1) ? int'(COORD_MAX) : 0);
        end
        9: begin
          xv = int'(COORD_MAX) - int'($urandom_range(1));
          yv = int'($urandom_range(COORD_MAX));
        end
        default: begin
          xv = int'($urandom_range(COORD_MAX));
          yv = int'($urandom_range(COORD_MAX));
        end
      endcase
      send_point(mk_point(xv, yv, i == len - 1));
    end
  endtask

  initial begin
    int unsigned base;
    int unsigned len;
    int unsigned pick;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Single point closes the set: zero denominator.
    send_point(mk_point(0, 0, 1'b1));
    // All points share one x: zero denominator.
    send_point(mk_point(4095, 0, 1'b0));
    send_point(mk_point(4095, 4095, 1'b0));
    send_point(mk_point(4095, 17, 1'b1));
    // Unit diagonal across the full range.
    send_point(mk_point(0, 0, 1'b0));
    send_point(mk_point(4095, 4095, 1'b1));
    // Steepest slope that still fits.
    send_point(mk_point(0, 0, 1'b0));
    send_point(mk_point(1, 4095, 1'b1));
    // Intercept clamps low, then high.
    send_point(mk_point(4094, 0, 1'b0));
    send_point(mk_point(4095, 4095, 1'b1));
    send_point(mk_point(4094, 4095, 1'b0));
    send_point(mk_point(4095, 0, 1'b1));
    // Negative fractional slope: truncate toward zero.
    send_point(mk_point(0, 10, 1'b0));
    send_point(mk_point(3, 9, 1'b0));
    send_point(mk_point(7, 1, 1'b1));
    // Alternating bit patterns on both coordinates.
    send_point(mk_point(4095, 4095, 1'b0));
    send_point(mk_point(0, 0, 1'b0));
    send_point(mk_point('hAAA, 'h555, 1'b0));
    send_point(mk_point('h555, 'hAAA, 1'b1));
    drain_fits();

    base = sent_cnt;
    while (sent_cnt - base < RAND_ITEMS) begin
      calm = (sent_cnt - base >= 300) && (sent_cnt - base < 600);
      pick = $urandom_range(99);
      if (pick < 70)      len = $urandom_range(2, 12);
      else if (pick < 85) len = $urandom_range(1, 40);
      else if (pick < 95) len = 1;
      else                len = $urandom_range(41, 200);
      send_random_set(len);
      if (sent_cnt - base >= RAND_ITEMS / 2 && sent_cnt - base < RAND_ITEMS / 2 + len)
        drain_fits();
    end
    calm = 1'b0;

    drain_fits();
    repeat (TAIL_WAIT) @(posedge clk_i);
    if (sb.fails == 0 && sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+src
src/lsf_pkg.sv
src/lsf_mul.sv
src/lsf_div.sv
src/lsf_datapath.sv
src/lsf_ctrl.sv
src/least_squares_line_fit.sv
tb/tb_top.sv
